@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Beat types, command and status codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLOCK_W  = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int TSIZE_W  = 13;
  localparam int CFG_W    = 16;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd2;

  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_BASE_BLOCK = 1'b1;

  localparam logic [TSIZE_W-1:0] TABLE_SIZE_RESET = 13'd4096;
  localparam logic [BLOCK_W-1:0] BASE_BLOCK_RESET = 16'd0;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [BLOCK_W-1:0] blk_num;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  allocated_block;
  } out_item_t;

endpackage

@@ rtl/core/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a usage bitmap held in one word-wide RAM.
//
//   channel   dir   handshake             beat
//   in        in    in_valid / in_ready   bba_pkg::in_item_t
//   out       out   out_valid / out_ready bba_pkg::out_item_t
//   cfg       in    cfg_we                cfg_index, cfg_data
//
// One item at a time: in_ready stays low until the result is registered out.
// Free and mark-used: range check, reciprocal multiply, remainder with RAM read,
// read-modify-write. Allocate scans the bitmap one RAM word per cycle (at most
// 64 words by default) up to the first free bit; table size zero reports full.
// After reset a clearing pass zeroes one RAM word per cycle, 64 words by default,
// with in_ready low. A stalled out channel holds the next result in the final step.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bba_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bba_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_data
);

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int FIRST_W   = IDX_W + 1;
  localparam int SH        = IDX_W + BW;
  localparam int RECIP_W   = IDX_W + 2;
  localparam int PROD_W    = IDX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_SPLIT, S_MODIFY, S_SCAN, S_GRANT, S_FINISH
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   clr_cnt;
  logic [bba_pkg::TSIZE_W-1:0]     table_size;
  logic [bba_pkg::BLOCK_W-1:0]     base_block;
  logic [bba_pkg::CMD_W-1:0]       cmd_q;
  logic [bba_pkg::BLOCK_W-1:0]     bn_q;
  logic [IDX_W-1:0]                idx_q;
  logic [PROD_W-1:0]               prod_q;
  logic [AW-1:0]                   word_q;
  logic [BW-1:0]                   bit_q;
  logic [FIRST_W-1:0]              first_q;
  logic [WORD_BITS-1:0]            word_data_q;
  logic [bba_pkg::STATUS_W-1:0]    status_q;
  logic [bba_pkg::BLOCK_W-1:0]     granted_q;

  logic [FIRST_W-1:0]              size;
  logic [31:0]                     ts_wide;
  logic [bba_pkg::BLOCK_W-1:0]     free_diff;
  logic                            free_ok;
  logic                            mark_ok;
  logic [AW-1:0]                   quot;
  logic [IDX_W-1:0]                quot_times;
  logic [FIRST_W-1:0]              next_first;
  logic [FIRST_W-1:0]              grant_pos;
  logic                            grant_ok;
  logic [BW-1:0]                   low_zero;
  logic [WORD_BITS-1:0]            bit_mask;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [WORD_BITS-1:0]            ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [WORD_BITS-1:0]            ram_rdata;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);

  assign ts_wide    = 32'(table_size);
  assign size       = (ts_wide > 32'(MAX_BLOCKS)) ? FIRST_W'(MAX_BLOCKS) : FIRST_W'(ts_wide);
  assign free_diff  = bn_q - base_block;
  assign free_ok    = (bn_q >= base_block) && (32'(free_diff) < 32'(size));
  assign mark_ok    = (32'(bn_q) < 32'(size));
  assign quot       = AW'(prod_q >> SH);
  assign quot_times = IDX_W'(32'(quot) * 32'(WORD_BITS));
  assign next_first = first_q + FIRST_W'(WORD_BITS);
  assign grant_pos  = first_q + FIRST_W'(bit_q);
  assign grant_ok   = (grant_pos < size);
  assign bit_mask   = WORD_BITS'(1) << bit_q;

  always_comb begin
    low_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        low_zero = BW'(i);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = word_data_q | bit_mask;
    ram_raddr = quot;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_CHECK: begin
        ram_raddr = '0;
      end
      S_SCAN: begin
        ram_raddr = word_q + AW'(1);
      end
      S_MODIFY: begin
        ram_we    = 1'b1;
        ram_wdata = (cmd_q == bba_pkg::CMD_FREE) ? (ram_rdata & ~bit_mask)
                                                 : (ram_rdata | bit_mask);
      end
      S_GRANT: begin
        ram_we = grant_ok;
      end
      default: begin
        ram_raddr = quot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= bba_pkg::TABLE_SIZE_RESET;
      base_block <= bba_pkg::BASE_BLOCK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::REG_TABLE_SIZE: table_size <= cfg_data[bba_pkg::TSIZE_W-1:0];
        bba_pkg::REG_BASE_BLOCK: base_block <= cfg_data[bba_pkg::BLOCK_W-1:0];
        default: base_block <= base_block;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= in_data.command;
            bn_q  <= in_data.blk_num;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          granted_q <= '0;
          case (cmd_q)
            bba_pkg::CMD_ALLOC: begin
              if (size == '0) begin
                status_q <= bba_pkg::STATUS_FULL;
                state    <= S_FINISH;
              end else begin
                word_q  <= '0;
                first_q <= '0;
                state   <= S_SCAN;
              end
            end
            bba_pkg::CMD_FREE: begin
              if (free_ok) begin
                idx_q <= IDX_W'(free_diff);
                state <= S_DIV;
              end else begin
                status_q <= bba_pkg::STATUS_OOB;
                state    <= S_FINISH;
              end
            end
            bba_pkg::CMD_MARK: begin
              if (mark_ok) begin
                idx_q <= IDX_W'(bn_q);
                state <= S_DIV;
              end else begin
                status_q <= bba_pkg::STATUS_OOB;
                state    <= S_FINISH;
              end
            end
            default: begin
              status_q <= bba_pkg::STATUS_OOB;
              state    <= S_FINISH;
            end
          endcase
        end
        S_DIV: begin
          prod_q <= PROD_W'(idx_q) * PROD_W'(RECIP);
          state  <= S_SPLIT;
        end
        S_SPLIT: begin
          word_q <= quot;
          bit_q  <= BW'(idx_q - quot_times);
          state  <= S_MODIFY;
        end
        S_MODIFY: begin
          status_q <= bba_pkg::STATUS_OK;
          state    <= S_FINISH;
        end
        S_SCAN: begin
          if (&ram_rdata) begin
            if ((word_q == LAST_WORD) || (next_first >= size)) begin
              status_q <= bba_pkg::STATUS_FULL;
              state    <= S_FINISH;
            end else begin
              word_q  <= word_q + AW'(1);
              first_q <= next_first;
            end
          end else begin
            bit_q       <= low_zero;
            word_data_q <= ram_rdata;
            state       <= S_GRANT;
          end
        end
        S_GRANT: begin
          if (grant_ok) begin
            status_q  <= bba_pkg::STATUS_OK;
            granted_q <= bba_pkg::BLOCK_W'(grant_pos) + base_block;
          end else begin
            status_q <= bba_pkg::STATUS_FULL;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_data.status          <= status_q;
            out_data.allocated_block <= granted_q;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
